// ----- rtl/cas3d_pkg.sv -----
// ----------------------------------------------------------------------------
// cas3d_pkg: shared types and constants
// Widths, register indexes and controller-to-datapath command types.
// ----------------------------------------------------------------------------
package cas3d_pkg;

  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int MAX_Z = 64;
  localparam int STORE_DEPTH = 2 * MAX_X * MAX_Y + 1;
  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CNT_W = 19;

  localparam logic [2:0] REG_DIM_X  = 3'd0;
  localparam logic [2:0] REG_DIM_Y  = 3'd1;
  localparam logic [2:0] REG_DIM_Z  = 3'd2;
  localparam logic [2:0] REG_INV_DX = 3'd3;
  localparam logic [2:0] REG_INV_DY = 3'd4;
  localparam logic [2:0] REG_INV_DZ = 3'd5;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [2:0]        rd_sel;
    logic [ADDR_W-1:0] rd_addr;
    logic [2:0]        steps_x;
    logic [2:0]        steps_y;
    logic [2:0]        steps_z;
    logic              calc_en;
    logic              acc_en;
    logic              mul_clr;
    logic [1:0]        mul_axis;
    logic              fin_en;
    logic [17:0]       voxel_index;
    logic              frame_last;
  } dp_cmd_t;

  // Sign-extend a Q7.8 value to 17 bits
  function automatic logic signed [16:0] sx17(input logic [15:0] v);
    sx17 = {v[15], v};
  endfunction

endpackage

// ----- rtl/cas3d_if.sv -----
// ----------------------------------------------------------------------------
// cas3d_if: valid/ready channel interfaces
// Input, output and configuration channels.
// ----------------------------------------------------------------------------
interface cas3d_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] vel_x;
  logic [15:0] vel_y;
  logic [15:0] vel_z;
  modport source (output valid, opcode, vel_x, vel_y, vel_z, input ready);
  modport sink   (input valid, opcode, vel_x, vel_y, vel_z, output ready);
endinterface

interface cas3d_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] acc_x;
  logic [31:0] acc_y;
  logic [31:0] acc_z;
  logic [17:0] voxel_index;
  logic        frame_last;
  modport source (output valid, acc_x, acc_y, acc_z, voxel_index, frame_last,
                  input ready);
  modport sink   (input valid, acc_x, acc_y, acc_z, voxel_index, frame_last,
                  output ready);
endinterface

interface cas3d_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/cas3d_datapath.sv -----
// ----------------------------------------------------------------------------
// cas3d_datapath: plane store and Jacobian arithmetic
// Ring memory of velocity triplets, one read per cycle into a neighbor file,
// three shared 17x16 multipliers for derivatives, three 35x16 multipliers for
// products, accumulation, rounding and saturation.
// ----------------------------------------------------------------------------
module cas3d_datapath (
  input  logic                    clk,
  input  cas3d_pkg::dp_cmd_t      cmd,
  input  logic [47:0]             wr_data,
  input  logic [15:0]             inv_dx,
  input  logic [15:0]             inv_dy,
  input  logic [15:0]             inv_dz,
  output logic [31:0]             res_x,
  output logic [31:0]             res_y,
  output logic [31:0]             res_z,
  output logic [17:0]             res_index,
  output logic                    res_last
);
  import cas3d_pkg::*;

  logic [47:0] mem [STORE_DEPTH];
  logic [47:0] rd_q_r;
  logic [2:0]  rd_sel_q_r;
  logic        rd_vld_q_r;
  // neighbor file: 0 center, 1 xlo, 2 xhi, 3 ylo, 4 yhi, 5 zlo, 6 zhi
  logic [47:0] nb_r [7];

  // memory port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) mem[cmd.wr_addr] <= wr_data;
    if (cmd.rd_en) rd_q_r <= mem[cmd.rd_addr];
    rd_sel_q_r <= cmd.rd_sel;
    rd_vld_q_r <= cmd.rd_en;
  end

  always_ff @(posedge clk) begin
    if (rd_vld_q_r && rd_sel_q_r != 3'd7) nb_r[rd_sel_q_r] <= rd_q_r;
  end

  // derivative stage: one Jacobian column (one axis) per cycle
  logic [1:0]          ax;
  logic [15:0]         inv_sel;
  logic [2:0]          steps_sel;
  logic [47:0]         hi_v, lo_v;
  logic signed [16:0]  dif [3];
  logic signed [33:0]  dprod [3];
  logic signed [34:0]  jac_r [3][3];

  assign ax = cmd.mul_axis;
  always_comb begin
    unique case (ax)
      2'd0: begin inv_sel = inv_dx; steps_sel = cmd.steps_x;
        hi_v = nb_r[2]; lo_v = nb_r[1]; end
      2'd1: begin inv_sel = inv_dy; steps_sel = cmd.steps_y;
        hi_v = nb_r[4]; lo_v = nb_r[3]; end
      default: begin inv_sel = inv_dz; steps_sel = cmd.steps_z;
        hi_v = nb_r[6]; lo_v = nb_r[5]; end
    endcase
    for (int c = 0; c < 3; c++) begin
      dif[c] = sx17(hi_v[16*c +: 16]) - sx17(lo_v[16*c +: 16]);
      dprod[c] = dif[c] * $signed({1'b0, inv_sel});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_en) begin
      for (int c = 0; c < 3; c++) begin
        if (steps_sel == 3'd2) jac_r[c][ax] <= 35'(dprod[c]);
        else if (steps_sel == 3'd1) jac_r[c][ax] <= {dprod[c], 1'b0};
        else jac_r[c][ax] <= '0;
      end
    end
  end

  // product stage: row c, term a = jac[c][a] * v[a]; one axis per cycle
  logic signed [15:0] vsel;
  logic signed [50:0] prod [3];
  logic signed [50:0] prod_r [3];
  logic               acc_vld_r;
  logic signed [52:0] sum_r [3];

  always_comb begin
    vsel = $signed(nb_r[0][16*ax +: 16]);
    for (int c = 0; c < 3; c++) prod[c] = jac_r[c][ax] * vsel;
  end

  // products are registered on acc_en and added into the sums in the cycle after
  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      for (int c = 0; c < 3; c++) prod_r[c] <= prod[c];
    end
    acc_vld_r <= cmd.acc_en;
    for (int c = 0; c < 3; c++) begin
      if (cmd.mul_clr) sum_r[c] <= '0;
      else if (acc_vld_r) sum_r[c] <= sum_r[c] + 53'(prod_r[c]);
    end
  end

  // rounding and saturation
  logic signed [52:0] rnd [3];
  logic signed [43:0] q [3];
  logic [31:0]        sat [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rnd[c] = sum_r[c] + 53'sd256;
      q[c] = rnd[c][52:9];
      if (q[c] > 44'sh0007FFFFFFF) sat[c] = 32'h7FFFFFFF;
      else if (q[c] < -44'sh00080000000) sat[c] = 32'h80000000;
      else sat[c] = q[c][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_en) begin
      res_x <= sat[0];
      res_y <= sat[1];
      res_z <= sat[2];
      res_index <= cmd.voxel_index;
      res_last <= cmd.frame_last;
    end
  end
endmodule

// ----- rtl/cas3d_ctrl.sv -----
// ----------------------------------------------------------------------------
// cas3d_ctrl: sequencer for push, drain and emit
// Keeps counts and config, fetches seven neighbors, steps the arithmetic.
// ----------------------------------------------------------------------------
module cas3d_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_opcode,
  output logic                    out_valid,
  input  logic                    out_ready,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [2:0]              cfg_index,
  input  logic [15:0]             cfg_data,
  output cas3d_pkg::dp_cmd_t      cmd,
  output logic [15:0]             inv_dx,
  output logic [15:0]             inv_dy,
  output logic [15:0]             inv_dz
);
  import cas3d_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SETUP = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_CALC = 3'd3;
  localparam logic [2:0] S_OUT = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [6:0] dim_x_r, dim_y_r, dim_z_r;
  logic [15:0] inv_dx_r, inv_dy_r, inv_dz_r;
  logic [CNT_W-1:0] in_cnt_r, out_cnt_r;
  logic [ADDR_W-1:0] wptr_r, rptr_r;
  logic [6:0] cx_r, cy_r, cz_r;
  logic [3:0] step_r;
  logic last_r;
  logic [1:0] dim_wait_r;

  logic [6:0] nx, ny, nz;
  logic [12:0] plane;
  logic [CNT_W-1:0] total;
  assign nx = (dim_x_r == 7'd0) ? 7'd1 : (dim_x_r > 7'(MAX_X)) ? 7'(MAX_X) : dim_x_r;
  assign ny = (dim_y_r == 7'd0) ? 7'd1 : (dim_y_r > 7'(MAX_Y)) ? 7'(MAX_Y) : dim_y_r;
  assign nz = (dim_z_r == 7'd0) ? 7'd1 : (dim_z_r > 7'(MAX_Z)) ? 7'(MAX_Z) : dim_z_r;

  // plane and total registered continuously to keep multipliers off path
  logic [12:0] plane_r;
  logic [CNT_W-1:0] total_r;
  always_ff @(posedge clk) begin
    plane_r <= 13'(nx) * 13'(ny);
    total_r <= CNT_W'(plane_r) * CNT_W'(nz);
  end
  assign plane = plane_r;
  assign total = total_r;

  logic in_fire, out_fire, cfg_fire, cfg_dim, push, drain_ok;
  // input waits after reset or a dimension write until plane and total settle
  assign in_ready = (state_r == S_IDLE) && dim_wait_r == 2'd0;
  assign cfg_ready = 1'b1;
  assign in_fire = in_valid && in_ready;
  assign out_valid = (state_r == S_OUT);
  assign out_fire = out_valid && out_ready;
  assign cfg_fire = cfg_valid && cfg_ready;
  assign cfg_dim = cfg_fire && (cfg_index == REG_DIM_X || cfg_index == REG_DIM_Y ||
                                cfg_index == REG_DIM_Z);
  assign push = in_fire && in_opcode == OP_PUSH && in_cnt_r < total;
  assign drain_ok = in_fire && in_opcode == OP_DRAIN && in_cnt_r >= total &&
                    out_cnt_r < total;

  function automatic logic [ADDR_W-1:0] ring_add(input logic [ADDR_W-1:0] a,
                                                 input logic [13:0] d);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + (ADDR_W+1)'(d);
    ring_add = (s >= (ADDR_W+1)'(STORE_DEPTH)) ? ADDR_W'(s - (ADDR_W+1)'(STORE_DEPTH))
                                                 : s[ADDR_W-1:0];
  endfunction
  function automatic logic [ADDR_W-1:0] ring_sub(input logic [ADDR_W-1:0] a,
                                                 input logic [13:0] d);
    logic [ADDR_W:0] s;
    s = {1'b0, a} + (ADDR_W+1)'(STORE_DEPTH) - (ADDR_W+1)'(d);
    ring_sub = (s >= (ADDR_W+1)'(STORE_DEPTH)) ? ADDR_W'(s - (ADDR_W+1)'(STORE_DEPTH))
                                                 : s[ADDR_W-1:0];
  endfunction

  // neighbor offsets for the current output voxel
  logic xlo, xhi, ylo, yhi, zlo, zhi;
  assign xlo = cx_r != 7'd0;
  assign xhi = (cx_r + 7'd1) < nx;
  assign ylo = cy_r != 7'd0;
  assign yhi = (cy_r + 7'd1) < ny;
  assign zlo = cz_r != 7'd0;
  assign zhi = (cz_r + 7'd1) < nz;

  logic [ADDR_W-1:0] fetch_addr;
  always_comb begin
    unique case (step_r)
      4'd1: fetch_addr = xlo ? ring_sub(rptr_r, 14'd1) : rptr_r;
      4'd2: fetch_addr = xhi ? ring_add(rptr_r, 14'd1) : rptr_r;
      4'd3: fetch_addr = ylo ? ring_sub(rptr_r, 14'(nx)) : rptr_r;
      4'd4: fetch_addr = yhi ? ring_add(rptr_r, 14'(nx)) : rptr_r;
      4'd5: fetch_addr = zlo ? ring_sub(rptr_r, 14'(plane)) : rptr_r;
      4'd6: fetch_addr = zhi ? ring_add(rptr_r, 14'(plane)) : rptr_r;
      default: fetch_addr = rptr_r;
    endcase
  end

  logic emit_go;
  always_comb begin
    state_nxt = state_r;
    emit_go = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (push && (CNT_W'(in_cnt_r + 1'b1) >= CNT_W'(out_cnt_r + CNT_W'(plane) + 1'b1)))
          emit_go = 1'b1;
        if (drain_ok) emit_go = 1'b1;
        if (emit_go) state_nxt = S_SETUP;
      end
      S_SETUP: state_nxt = S_FETCH;
      S_FETCH: if (step_r == 4'd8) state_nxt = S_CALC;
      S_CALC:  if (step_r == 4'd7) state_nxt = S_OUT;
      S_OUT:   if (out_fire) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      in_cnt_r <= '0; out_cnt_r <= '0; wptr_r <= '0; rptr_r <= '0;
      cx_r <= '0; cy_r <= '0; cz_r <= '0; step_r <= '0; last_r <= 1'b0;
      dim_x_r <= 7'd64; dim_y_r <= 7'd64; dim_z_r <= 7'd64;
      inv_dx_r <= 16'd256; inv_dy_r <= 16'd256; inv_dz_r <= 16'd256;
      dim_wait_r <= 2'd2;
    end else begin
      state_r <= state_nxt;
      dim_wait_r <= cfg_dim ? 2'd2 : (dim_wait_r != 2'd0) ? dim_wait_r - 2'd1 : 2'd0;
      if (cfg_fire) begin
        unique case (cfg_index)
          REG_DIM_X: dim_x_r <= cfg_data[6:0];
          REG_DIM_Y: dim_y_r <= cfg_data[6:0];
          REG_DIM_Z: dim_z_r <= cfg_data[6:0];
          REG_INV_DX: inv_dx_r <= cfg_data;
          REG_INV_DY: inv_dy_r <= cfg_data;
          REG_INV_DZ: inv_dz_r <= cfg_data;
          default: ;
        endcase
        if (cfg_dim) begin
          in_cnt_r <= '0; out_cnt_r <= '0; wptr_r <= '0; rptr_r <= '0;
          cx_r <= '0; cy_r <= '0; cz_r <= '0;
        end
      end
      if (push) begin
        in_cnt_r <= in_cnt_r + 1'b1;
        wptr_r <= ring_add(wptr_r, 14'd1);
      end
      if (state_r == S_IDLE && emit_go) begin
        step_r <= '0;
        last_r <= drain_ok && (out_cnt_r + 1'b1 == total);
      end
      if (state_r == S_SETUP) step_r <= '0;
      if (state_r == S_FETCH) step_r <= (step_r == 4'd8) ? 4'd0 : step_r + 4'd1;
      if (state_r == S_CALC) step_r <= step_r + 4'd1;
      if (out_fire) begin
        if (last_r) begin
          in_cnt_r <= '0; out_cnt_r <= '0; wptr_r <= '0; rptr_r <= '0;
          cx_r <= '0; cy_r <= '0; cz_r <= '0;
        end else begin
          out_cnt_r <= out_cnt_r + 1'b1;
          rptr_r <= ring_add(rptr_r, 14'd1);
          if (cx_r + 7'd1 < nx) cx_r <= cx_r + 7'd1;
          else begin
            cx_r <= '0;
            if (cy_r + 7'd1 < ny) cy_r <= cy_r + 7'd1;
            else begin cy_r <= '0; cz_r <= cz_r + 7'd1; end
          end
        end
      end
    end
  end

  // command to datapath
  always_comb begin
    cmd = '0;
    cmd.wr_en = push;
    cmd.wr_addr = wptr_r;
    cmd.rd_en = (state_r == S_FETCH) && step_r < 4'd7;
    cmd.rd_sel = (state_r == S_FETCH && step_r < 4'd7) ? step_r[2:0] : 3'd7;
    cmd.rd_addr = fetch_addr;
    cmd.steps_x = 3'({1'b0, xlo} + {1'b0, xhi});
    cmd.steps_y = 3'({1'b0, ylo} + {1'b0, yhi});
    cmd.steps_z = 3'({1'b0, zlo} + {1'b0, zhi});
    // CALC steps: 0..2 derivatives, 3..5 products, 4..6 sums, 7 finish
    cmd.calc_en = (state_r == S_CALC) && step_r < 4'd3;
    cmd.mul_axis = (state_r == S_CALC && step_r < 4'd3) ? step_r[1:0] :
                   (state_r == S_CALC && step_r >= 4'd3 && step_r < 4'd6) ?
                   2'(step_r - 4'd3) : 2'd0;
    cmd.acc_en = (state_r == S_CALC) && step_r >= 4'd3 && step_r < 4'd6;
    cmd.mul_clr = (state_r == S_CALC) && step_r <= 4'd3;
    cmd.fin_en = (state_r == S_CALC) && step_r == 4'd7;
    cmd.voxel_index = out_cnt_r[17:0];
    cmd.frame_last = last_r;
  end

  assign inv_dx = inv_dx_r;
  assign inv_dy = inv_dy_r;
  assign inv_dz = inv_dz_r;

  // checks
  a_cnt_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_cnt_r <= in_cnt_r) else $error("out count ahead of in count");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_ready) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
endmodule

// ----- rtl/convective_acceleration_stencil_3d_core.sv -----
// ----------------------------------------------------------------------------
// convective_acceleration_stencil_3d_core: (grad v) * v over a streamed grid
// Controller sequences seven neighbor reads and three derivative/product
// steps; datapath holds the plane ring and arithmetic.
// ----------------------------------------------------------------------------
//   channel  dir  contents
//   in_      in   opcode, vel_x, vel_y, vel_z
//   out_     out  acc_x, acc_y, acc_z, voxel_index, frame_last
//   cfg_     in   index (0..5), data
// A push with no result leaves the input ready for the next item. An item
// with a result holds off input until the result is taken: the controller
// steps through SETUP, FETCH (seven reads on the single memory read port),
// CALC (the shared derivative and product multipliers) and OUT.
// Reset is synchronous; the store is not cleared. Input is held off after
// reset or a dimension write until plane and total settle, while a result
// is being formed, and while a result waits at the output.
// ----------------------------------------------------------------------------
module convective_acceleration_stencil_3d_core (
  input logic        clk,
  input logic        rst_n,
  cas3d_in_if.sink   in_ch,
  cas3d_out_if.source out_ch,
  cas3d_cfg_if.sink  cfg_ch
);
  import cas3d_pkg::*;

  dp_cmd_t     cmd;
  logic [15:0] inv_dx, inv_dy, inv_dz;

  cas3d_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_opcode(in_ch.opcode),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .cfg_valid(cfg_ch.valid), .cfg_ready(cfg_ch.ready),
    .cfg_index(cfg_ch.index), .cfg_data(cfg_ch.data),
    .cmd(cmd), .inv_dx(inv_dx), .inv_dy(inv_dy), .inv_dz(inv_dz)
  );

  cas3d_datapath u_dp (
    .clk(clk), .cmd(cmd),
    .wr_data({in_ch.vel_z, in_ch.vel_y, in_ch.vel_x}),
    .inv_dx(inv_dx), .inv_dy(inv_dy), .inv_dz(inv_dz),
    .res_x(out_ch.acc_x), .res_y(out_ch.acc_y), .res_z(out_ch.acc_z),
    .res_index(out_ch.voxel_index), .res_last(out_ch.frame_last)
  );
endmodule

// ----- dv/cas3d_checker.sv -----
// ----------------------------------------------------------------------------
// cas3d_checker: acceleration predictor and result scoreboard
// Watches the config, input and result channels. It mirrors the plane window
// and the frame counters, predicts each acceleration result and compares the
// results field by field, in order.
// ----------------------------------------------------------------------------
module cas3d_checker
  import cas3d_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  cas3d_in_if   in_ch,
  cas3d_out_if  out_ch,
  cas3d_cfg_if  cfg_ch,
  output int    fail_count,
  output int    pending,
  output int    results_seen
);

  typedef struct packed {
    logic [31:0] acc_x;
    logic [31:0] acc_y;
    logic [31:0] acc_z;
    logic [17:0] voxel_index;
    logic        frame_last;
  } accel_t;

  logic signed [15:0] vel_window [STORE_DEPTH][3];
  int                 in_cnt, out_cnt;
  logic [6:0]         dim_reg [3];
  logic [15:0]        inv_reg [3];
  accel_t             accel_q [$];

  assign pending = accel_q.size();

  function automatic int axis_len(logic [6:0] r, int mx);
    if (r < 1) return 1;
    if (r > mx) return mx;
    return r;
  endfunction

  // Jacobian of the window around voxel p, times the voxel's own velocity
  function automatic accel_t predict_accel(int p, int nx, int ny, int nz);
    int       coord [3];
    int       size [3];
    int       stride [3];
    int       lo, hi, ilo, ihi;
    longint   jac [3][3];
    longint   s, q, mult;
    logic [31:0] r [3];
    accel_t   a;
    coord[0] = p % nx; coord[1] = (p / nx) % ny; coord[2] = p / (nx * ny);
    size[0] = nx; size[1] = ny; size[2] = nz;
    stride[0] = 1; stride[1] = nx; stride[2] = nx * ny;
    for (int ax = 0; ax < 3; ax++) begin
      lo = coord[ax] > 0 ? coord[ax] - 1 : coord[ax];
      hi = coord[ax] + 1 < size[ax] ? coord[ax] + 1 : coord[ax];
      ilo = (p - (coord[ax] - lo) * stride[ax]) % STORE_DEPTH;
      ihi = (p + (hi - coord[ax]) * stride[ax]) % STORE_DEPTH;
      // two-step difference as is, one-step doubled, size-one axis zero
      mult = (hi - lo == 2) ? 1 : ((hi - lo == 1) ? 2 : 0);
      for (int c = 0; c < 3; c++)
        jac[c][ax] = (longint'(vel_window[ihi][c]) - longint'(vel_window[ilo][c]))
                     * longint'({1'b0, inv_reg[ax]}) * mult;
    end
    for (int c = 0; c < 3; c++) begin
      s = 0;
      for (int ax = 0; ax < 3; ax++)
        s += jac[c][ax] * longint'(vel_window[p % STORE_DEPTH][ax]);
      q = (s + 256) >>> 9;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      r[c] = q[31:0];
    end
    a.acc_x = r[0]; a.acc_y = r[1]; a.acc_z = r[2];
    a.voxel_index = p[17:0];
    a.frame_last = 1'b0;
    return a;
  endfunction

  always @(posedge clk) begin
    int     nx, ny, nz, plane, total;
    accel_t exp_a, got;
    if (!rst_n) begin
      in_cnt <= 0;
      out_cnt <= 0;
      for (int i = 0; i < 3; i++) begin
        dim_reg[i] = 7'd64;
        inv_reg[i] = 16'd256;
      end
      accel_q.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      // results first: they come from items accepted earlier
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.acc_x, out_ch.acc_y, out_ch.acc_z, out_ch.voxel_index,
                out_ch.frame_last};
        results_seen <= results_seen + 1;
        if (accel_q.size() == 0) begin
          $display("%0t: unexpected result, actual %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_a = accel_q.pop_front();
          if (got.acc_x !== exp_a.acc_x || got.acc_y !== exp_a.acc_y ||
              got.acc_z !== exp_a.acc_z || got.voxel_index !== exp_a.voxel_index ||
              got.frame_last !== exp_a.frame_last) begin
            $display("%0t: mismatch voxel %0d: expected acc %h %h %h idx %0d last %b,",
                     $time, exp_a.voxel_index, exp_a.acc_x, exp_a.acc_y, exp_a.acc_z,
                     exp_a.voxel_index, exp_a.frame_last);
            $display("%0t:   actual acc %h %h %h idx %0d last %b", $time, got.acc_x,
                     got.acc_y, got.acc_z, got.voxel_index, got.frame_last);
            fail_count <= fail_count + 1;
          end
        end
      end
      // register writes; a dimension write restarts the frame
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          REG_DIM_X:  begin dim_reg[0] = cfg_ch.data[6:0]; in_cnt <= 0; out_cnt <= 0; end
          REG_DIM_Y:  begin dim_reg[1] = cfg_ch.data[6:0]; in_cnt <= 0; out_cnt <= 0; end
          REG_DIM_Z:  begin dim_reg[2] = cfg_ch.data[6:0]; in_cnt <= 0; out_cnt <= 0; end
          REG_INV_DX: inv_reg[0] = cfg_ch.data;
          REG_INV_DY: inv_reg[1] = cfg_ch.data;
          REG_INV_DZ: inv_reg[2] = cfg_ch.data;
          default: ;
        endcase
      end
      // input items
      if (in_ch.valid && in_ch.ready) begin
        nx = axis_len(dim_reg[0], MAX_X);
        ny = axis_len(dim_reg[1], MAX_Y);
        nz = axis_len(dim_reg[2], MAX_Z);
        plane = nx * ny;
        total = plane * nz;
        if (in_ch.opcode == OP_PUSH) begin
          if (in_cnt < total) begin
            vel_window[in_cnt % STORE_DEPTH][0] = in_ch.vel_x;
            vel_window[in_cnt % STORE_DEPTH][1] = in_ch.vel_y;
            vel_window[in_cnt % STORE_DEPTH][2] = in_ch.vel_z;
            in_cnt <= in_cnt + 1;
            if (in_cnt + 1 >= out_cnt + plane + 1) begin
              accel_q.push_back(predict_accel(out_cnt, nx, ny, nz));
              out_cnt <= out_cnt + 1;
            end
          end
        end else if (in_cnt >= total && out_cnt < total) begin
          exp_a = predict_accel(out_cnt, nx, ny, nz);
          if (out_cnt + 1 == total) begin
            exp_a.frame_last = 1'b1;
            in_cnt <= 0;
            out_cnt <= 0;
          end else begin
            out_cnt <= out_cnt + 1;
          end
          accel_q.push_back(exp_a);
        end
      end
    end
  end

endmodule

// ----- dv/tb_convective_acceleration_stencil_3d_core.sv -----
// ----------------------------------------------------------------------------
// tb_convective_acceleration_stencil_3d_core: stimulus and verdict
// Streams small velocity volumes with random content and noise items across
// many grid sizes and spacings, with random idling on both channels. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_convective_acceleration_stencil_3d_core;
  import cas3d_pkg::*;

  logic clk;
  logic rst_n;
  logic idle_en;
  int   items_sent;
  int   frames_done;
  int   fail_count, pending, results_seen;
  int   stall_left;
  int   gx, gy, gz;

  cas3d_in_if  in_ch ();
  cas3d_out_if out_ch ();
  cas3d_cfg_if cfg_ch ();

  convective_acceleration_stencil_3d_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  cas3d_checker chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending), .results_seen(results_seen)
  );

  // clock
  always begin
    clk = 1'b1; #4;
    clk = 1'b0; #4;
  end

  // result side stalls in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 4);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  function automatic int axis_len(int r, int mx);
    return r < 1 ? 1 : (r > mx ? mx : r);
  endfunction

  function automatic logic [15:0] rand_vel();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_inv();
    case ($urandom_range(0, 5))
      0: return 16'h0000;
      1: return 16'hffff;
      2: return 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  // one item on the input channel; starts and ends at a falling edge
  task automatic send_item(logic op, logic [15:0] vx, logic [15:0] vy, logic [15:0] vz);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.opcode = op;
    in_ch.vel_x = vx;
    in_ch.vel_y = vy;
    in_ch.vel_z = vz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    in_ch.valid = 1'b0;
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data = val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // let every expected result arrive, then cover the block's own latency
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic set_grid(int dx, int dy, int dz, logic [15:0] ix, logic [15:0] iy,
                          logic [15:0] iz);
    write_reg(REG_DIM_X, 16'(dx));
    write_reg(REG_DIM_Y, 16'(dy));
    write_reg(REG_DIM_Z, 16'(dz));
    write_reg(REG_INV_DX, ix);
    write_reg(REG_INV_DY, iy);
    write_reg(REG_INV_DZ, iz);
    gx = axis_len(dx, MAX_X);
    gy = axis_len(dy, MAX_Y);
    gz = axis_len(dz, MAX_Z);
  endtask

  // push a volume with noise drains; cut short when abort is set,
  // else drain the last plane with an ignored push now and then
  task automatic run_volume(bit abort);
    int total, stop, flush;
    total = gx * gy * gz;
    stop = abort ? $urandom_range(0, total - 1) : total;
    for (int i = 0; i < stop; i++) begin
      if ($urandom_range(0, 11) == 0)
        send_item(OP_DRAIN, rand_vel(), rand_vel(), rand_vel());
      send_item(OP_PUSH, rand_vel(), rand_vel(), rand_vel());
    end
    if (abort) return;
    flush = total < gx * gy ? total : gx * gy;
    for (int i = 0; i < flush; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(OP_PUSH, rand_vel(), rand_vel(), rand_vel());
      send_item(OP_DRAIN, rand_vel(), rand_vel(), rand_vel());
    end
    frames_done++;
  endtask

  initial begin
    int dx, dy, dz;
    rst_n = 1'b0;
    idle_en = 1'b1;
    items_sent = 0;
    frames_done = 0;
    in_ch.valid = 1'b0;
    in_ch.opcode = OP_PUSH;
    in_ch.vel_x = '0;
    in_ch.vel_y = '0;
    in_ch.vel_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // single voxel, largest magnitudes on size-one axes, whose derivatives are zero
    set_grid(1, 1, 1, 16'hffff, 16'hffff, 16'hffff);
    send_item(OP_DRAIN, 16'h0, 16'h0, 16'h0);
    send_item(OP_PUSH, 16'h8000, 16'h7fff, 16'h8000);
    send_item(OP_DRAIN, 16'h0, 16'h0, 16'h0);
    send_item(OP_DRAIN, 16'h0, 16'h0, 16'h0);
    settle();
    // zero dims act as one; unknown register indexes are ignored
    write_reg(3'd6, 16'hffff);
    write_reg(3'd7, 16'h1234);
    set_grid(0, 0, 0, 16'h0, 16'd256, 16'hffff);
    send_item(OP_PUSH, 16'h7fff, 16'h7fff, 16'h7fff);
    send_item(OP_DRAIN, 16'h0, 16'h0, 16'h0);
    settle();
    // 2x2x2 with early drain, ignored push and drain with nothing pending
    set_grid(2, 2, 2, 16'hffff, 16'h0100, 16'h8000);
    send_item(OP_PUSH, 16'h7fff, 16'h8000, 16'h0001);
    send_item(OP_DRAIN, 16'h0, 16'h0, 16'h0);
    for (int i = 0; i < 7; i++) send_item(OP_PUSH, rand_vel(), rand_vel(), rand_vel());
    send_item(OP_PUSH, 16'hffff, 16'hffff, 16'hffff);
    for (int i = 0; i < 4; i++) send_item(OP_DRAIN, 16'h0, 16'h0, 16'h0);
    send_item(OP_DRAIN, 16'h0, 16'h0, 16'h0);
    settle();

    // random volumes; now and then a long row or a restart mid-volume
    while (items_sent < 1900) begin
      if (items_sent > 1600) idle_en = 1'b0;
      case ($urandom_range(0, 9))
        0: begin dx = 127; dy = 1; dz = 1; end
        1: begin dx = 1; dy = $urandom_range(0, 6); dz = 127; end
        default: begin
          dx = $urandom_range(0, 6);
          dy = $urandom_range(1, 5);
          dz = $urandom_range(0, 5);
        end
      endcase
      set_grid(dx, dy, dz, rand_inv(), rand_inv(), rand_inv());
      run_volume($urandom_range(0, 7) == 0);
      settle();
    end

    $display("Ran %0d input items over %0d full volumes; %0d results checked.",
             items_sent, frames_done, results_seen);
    if (fail_count == 0)
      $display("PASS convective_acceleration_stencil_3d_core");
    else
      $display("FAIL convective_acceleration_stencil_3d_core");
    $finish;
  end

  // watchdog
  initial begin
    #40000000;
    $display("FAIL convective_acceleration_stencil_3d_core");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cas3d_pkg.sv
rtl/cas3d_if.sv
rtl/cas3d_datapath.sv
rtl/cas3d_ctrl.sv
rtl/convective_acceleration_stencil_3d_core.sv
dv/cas3d_checker.sv
dv/tb_convective_acceleration_stencil_3d_core.sv
